// ----- sv/murmur_hash_64a_stream_macros.svh -----
// Assertion macros for the checker of the hash stream block.
// No dependencies; included by the checker module.
`ifndef MURMUR_HASH_64A_STREAM_MACROS_SVH
`define MURMUR_HASH_64A_STREAM_MACROS_SVH

// Same-cycle implication, checked at every rising edge unless dis is high.
`define MMH_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge unless dis is high.
`define MMH_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mmh64_pkg.sv -----
// Package for the MurmurHash2 64A stream block: widths, constants, control types.
// No dependencies; imported by every module of the block.
`default_nettype none

package mmh64_pkg;

    localparam int DATA_W    = 64;
    localparam int CNT_W     = 4;
    localparam int LEN_W     = 31;
    localparam int BYTES_W   = 32;
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 64;

    localparam logic [DATA_W-1:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int                MIX_SHIFT = 47;

    localparam logic [CNT_W-1:0] CNT_FULL = 4'd8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_INIT_MUL,
        S_INIT_WAIT,
        S_DATA,
        S_W1_MUL,
        S_W1_WAIT,
        S_W2_MUL,
        S_W2_WAIT,
        S_W3_MUL,
        S_W3_WAIT,
        S_T_MUL,
        S_T_WAIT,
        S_F_MUL,
        S_F_WAIT,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        SRC_LEN,
        SRC_WORD,
        SRC_KMIX,
        SRC_HASH,
        SRC_FIN
    } t_mul_src;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_INIT,
        WB_K,
        WB_HXOR,
        WB_HSET,
        WB_OUT
    } t_wb;

    typedef struct packed {
        logic     take;
        logic     data_step;
        logic     mul_start;
        t_mul_src mul_src;
        t_wb      wb;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic first;
        logic last;
        logic cnt_full;
        logic cnt_tail;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- sv/mmh64_datapath.sv -----
// Datapath of the hash stream block: hash state, input and output registers,
// and a shared multiplier by the mix constant. Depends on mmh64_pkg.
`default_nettype none

module mmh64_datapath
    import mmh64_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic [DATA_W-1:0]  i_cfg_data,
    input  wire logic [DATA_W-1:0]  i_data_word,
    input  wire logic [CNT_W-1:0]   i_byte_count,
    input  wire logic               i_first,
    input  wire logic               i_last,
    input  wire logic [LEN_W-1:0]   i_total_length,
    input  wire logic               i_out_ready,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_status,
    output logic                    o_out_valid,
    output logic [DATA_W-1:0]       o_hash_value,
    output logic                    o_length_error
);

    logic [DATA_W-1:0]  r_seed;
    logic [DATA_W-1:0]  r_hash;
    logic [BYTES_W-1:0] r_bytes;
    logic [LEN_W-1:0]   r_exp;
    logic               r_fault;

    logic [DATA_W-1:0]  r_word;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_first;
    logic               r_last;
    logic [LEN_W-1:0]   r_len;
    logic [DATA_W-1:0]  r_k;

    logic [DATA_W-1:0]  r_mop;
    logic [DATA_W-1:0]  r_prod;
    logic [DATA_W-1:0]  r_acc;
    logic [1:0]         r_mph;
    logic               r_mbusy;
    logic               r_mdone;

    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_hash;
    logic               r_out_err;

    logic [DATA_W-1:0]  mul_operand;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [DATA_W-1:0]  mul_p;
    logic [DATA_W-1:0]  tail_word;
    logic               cnt_tail;
    logic               out_free;

    assign cnt_tail = (r_cnt != '0) && (r_cnt < CNT_FULL);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            tail_word[8*b +: 8] = (4'(b) < r_cnt) ? r_word[8*b +: 8] : 8'd0;
        end
    end

    always_comb begin
        case (i_cmd.mul_src)
            SRC_LEN:  mul_operand = {{(DATA_W-LEN_W){1'b0}}, r_len};
            SRC_WORD: mul_operand = r_word;
            SRC_KMIX: mul_operand = r_k ^ (r_k >> MIX_SHIFT);
            SRC_HASH: mul_operand = r_hash;
            SRC_FIN:  mul_operand = r_hash ^ (r_hash >> MIX_SHIFT);
            default:  mul_operand = r_hash;
        endcase
    end

    // Low 64 bits of operand times constant from three 32x32 partial products.
    assign mul_a = (r_mph == 2'd1) ? r_mop[63:32] : r_mop[31:0];
    assign mul_b = (r_mph == 2'd2) ? MIX_MUL[63:32] : MIX_MUL[31:0];
    assign mul_p = DATA_W'(mul_a) * DATA_W'(mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mph   <= 2'd0;
        end else begin
            r_mdone <= r_mbusy && (r_mph == 2'd3);
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mph   <= 2'd0;
            end else if (r_mbusy) begin
                r_mph <= r_mph + 2'd1;
                if (r_mph == 2'd3) begin
                    r_mbusy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mop <= mul_operand;
        end
        if (r_mbusy) begin
            case (r_mph)
                2'd0: begin
                    r_prod <= mul_p;
                end
                2'd1: begin
                    r_acc  <= r_prod;
                    r_prod <= mul_p;
                end
                default: begin
                    r_acc  <= r_acc + {r_prod[31:0], 32'd0};
                    r_prod <= mul_p;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_word  <= i_data_word;
            r_cnt   <= i_byte_count;
            r_first <= i_first;
            r_last  <= i_last;
            r_len   <= i_total_length;
        end
        if (i_cmd.wb == WB_K) begin
            r_k <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= '0;
            r_hash  <= '0;
            r_bytes <= '0;
            r_exp   <= '0;
            r_fault <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
            if (i_cmd.data_step) begin
                if ((r_cnt > CNT_FULL) || ((r_cnt < CNT_FULL) && !r_last)) begin
                    r_fault <= 1'b1;
                end
                if (cnt_tail) begin
                    r_hash <= r_hash ^ tail_word;
                end
            end
            case (i_cmd.wb)
                WB_INIT: begin
                    r_hash  <= r_seed ^ r_acc;
                    r_bytes <= '0;
                    r_fault <= 1'b0;
                    r_exp   <= r_len;
                end
                WB_HXOR: begin
                    r_hash <= r_hash ^ r_acc;
                end
                WB_HSET: begin
                    r_hash  <= r_acc;
                    r_bytes <= r_bytes + BYTES_W'(r_cnt);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.wb == WB_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb == WB_OUT) begin
            r_out_hash <= r_acc ^ (r_acc >> MIX_SHIFT);
            r_out_err  <= r_fault || (r_bytes != {1'b0, r_exp});
        end
    end

    always_comb begin
        o_status.mul_done = r_mdone;
        o_status.first    = r_first;
        o_status.last     = r_last;
        o_status.cnt_full = (r_cnt == CNT_FULL);
        o_status.cnt_tail = cnt_tail;
        o_status.out_free = out_free;
    end

    assign o_out_valid    = r_out_valid;
    assign o_hash_value   = r_out_hash;
    assign o_length_error = r_out_err;

endmodule

`default_nettype wire

// ----- sv/mmh64_controller.sv -----
// Controller of the hash stream block: sequences loading, word mixing, tail
// folding and finalization on the datapath. Depends on mmh64_pkg.
`default_nettype none

module mmh64_controller
    import mmh64_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire t_dp_status i_status,
    output logic            o_in_ready,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = i_status.first ? S_INIT_MUL : S_DATA;
            end
            S_INIT_MUL: n_state = S_INIT_WAIT;
            S_INIT_WAIT: begin
                if (i_status.mul_done) begin
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (i_status.cnt_full) begin
                    n_state = S_W1_MUL;
                end else if (i_status.cnt_tail) begin
                    n_state = S_T_MUL;
                end else begin
                    n_state = i_status.last ? S_F_MUL : S_IDLE;
                end
            end
            S_W1_MUL: n_state = S_W1_WAIT;
            S_W1_WAIT: begin
                if (i_status.mul_done) begin
                    n_state = S_W2_MUL;
                end
            end
            S_W2_MUL: n_state = S_W2_WAIT;
            S_W2_WAIT: begin
                if (i_status.mul_done) begin
                    n_state = S_W3_MUL;
                end
            end
            S_W3_MUL: n_state = S_W3_WAIT;
            S_W3_WAIT: begin
                if (i_status.mul_done) begin
                    n_state = i_status.last ? S_F_MUL : S_IDLE;
                end
            end
            S_T_MUL: n_state = S_T_WAIT;
            S_T_WAIT: begin
                if (i_status.mul_done) begin
                    n_state = i_status.last ? S_F_MUL : S_IDLE;
                end
            end
            S_F_MUL: n_state = S_F_WAIT;
            S_F_WAIT: begin
                if (i_status.mul_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.take        = 1'b0;
        o_cmd.data_step   = 1'b0;
        o_cmd.mul_start   = 1'b0;
        o_cmd.mul_src     = SRC_HASH;
        o_cmd.wb          = WB_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            S_LOAD: begin
            end
            S_INIT_MUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_src   = SRC_LEN;
            end
            S_INIT_WAIT: o_cmd.wb = i_status.mul_done ? WB_INIT : WB_NONE;
            S_DATA:      o_cmd.data_step = 1'b1;
            S_W1_MUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_src   = SRC_WORD;
            end
            S_W1_WAIT: o_cmd.wb = i_status.mul_done ? WB_K : WB_NONE;
            S_W2_MUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_src   = SRC_KMIX;
            end
            S_W2_WAIT: o_cmd.wb = i_status.mul_done ? WB_HXOR : WB_NONE;
            S_W3_MUL, S_T_MUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_src   = SRC_HASH;
            end
            S_W3_WAIT, S_T_WAIT: o_cmd.wb = i_status.mul_done ? WB_HSET : WB_NONE;
            S_F_MUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_src   = SRC_FIN;
            end
            S_F_WAIT: begin
            end
            S_EMIT: o_cmd.wb = i_status.out_free ? WB_OUT : WB_NONE;
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/murmur_hash_64a_stream.sv -----
// Top level of the MurmurHash2 64A stream block: ports, field packing and the
// controller and datapath instances. Depends on mmh64_pkg and both submodules.
//
//   Channel   Direction  Carries
//   s_axis    in         message words, byte counts, first flag, last flag, length
//   m_axis    out        finalized hash and length error flag
//   cfg       in         seed register writes
//
// Each item is loaded and stepped through its data state; a first item adds one
// 64-bit multiply, a full word three, a tail one, and a last item one to finalize.
// All multiplies share one 32x32 multiplier that forms three partial products.
// Reset clears the hash state, the seed and the output valid; no clearing pass.
// A waiting result does not block input; a finalized hash waits while the
// output register is still full.
`default_nettype none

module murmur_hash_64a_stream
    import mmh64_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // data_word[63:0], byte_count[67:64], total_length[98:68], zero fill
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // first[0]
    input  wire logic                 s_axis_tuser,
    input  wire logic                 s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // hash_value[63:0]
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // length_error[0]
    output logic                      m_axis_tuser,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [DATA_W-1:0]    i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    mmh64_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    mmh64_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_data_word    (s_axis_tdata[DATA_W-1:0]),
        .i_byte_count   (s_axis_tdata[DATA_W +: CNT_W]),
        .i_first        (s_axis_tuser),
        .i_last         (s_axis_tlast),
        .i_total_length (s_axis_tdata[DATA_W+CNT_W +: LEN_W]),
        .i_out_ready    (m_axis_tready),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (m_axis_tvalid),
        .o_hash_value   (m_axis_tdata),
        .o_length_error (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- sv/mmh64_checker.sv -----
// Port-level checker for the hash stream block, bound to the top level.
// Depends on mmh64_pkg and the assertion macro header.
`default_nettype none

`include "murmur_hash_64a_stream_macros.svh"

module mmh64_checker
    import mmh64_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tuser
);

    `MMH_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `MMH_ASSERT_NEXT(a_one_in_flight, i_clk, !i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in work")
    `MMH_ASSERT_NOW(a_result_ends_item, i_clk, !i_rst_n, $rose(m_axis_tvalid), $rose(s_axis_tready), "result appeared without finishing an item")
    `MMH_ASSERT_NEXT(a_reset_clears_out, i_clk, 1'b0, !i_rst_n, !m_axis_tvalid, "result valid after reset")

endmodule

bind murmur_hash_64a_stream mmh64_checker u_chk (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the MurmurHash2 64A stream block: directed table, then random
// messages under several seeds, each finalized hash compared against a local hash predictor
// or a value from the table. Depends on mmh64_pkg and murmur_hash_64a_stream.
`timescale 1ns / 100ps

module tb;
    import mmh64_pkg::*;

    localparam int RUN_ITEMS    = 2000;
    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE       = 60;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  cnt;
        logic        first;
        logic        last;
        logic [30:0] len;
    } t_hash_item;

    typedef struct {
        logic [63:0] hash;
        logic        err;
    } t_digest;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_ERR,
        CHK_TYPED
    } t_chk;

    typedef struct {
        t_hash_item it;
        t_chk       chk;
        t_digest    want;
    } t_dir_row;

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Rows are word, byte count, first, last, length, then how the result is checked and the expected digest.
    t_dir_row dir_rows [25] = '{
        '{'{64'h0, 4'd0, 1'b1, 1'b1, 31'd0}, CHK_TYPED, '{64'h0, 1'b0}},
        '{'{ONES, 4'd9, 1'b1, 1'b1, 31'd0}, CHK_TYPED, '{64'h0, 1'b1}},
        '{'{ONES, 4'd15, 1'b1, 1'b1, 31'd0}, CHK_TYPED, '{64'h0, 1'b1}},
        '{'{64'h0, 4'd8, 1'b1, 1'b1, 31'd8}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{ONES, 4'd8, 1'b1, 1'b1, 31'd8}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{ONES, 4'd1, 1'b1, 1'b1, 31'd1}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'h0123_4567_89ab_cdef, 4'd7, 1'b1, 1'b1, 31'd7}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'h1111_2222_3333_4444, 4'd8, 1'b1, 1'b0, 31'd24}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'h5555_6666_7777_8888, 4'd8, 1'b0, 1'b0, 31'd0}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'h9999_aaaa_bbbb_cccc, 4'd8, 1'b0, 1'b1, 31'd0}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'hdead_beef_cafe_f00d, 4'd8, 1'b1, 1'b0, 31'd13}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'hffff_ffff_ff00_1122, 4'd5, 1'b0, 1'b1, 31'd0}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'h0f0f_0f0f_0f0f_0f0f, 4'd8, 1'b1, 1'b0, 31'd8}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{ONES, 4'd0, 1'b0, 1'b1, 31'd0}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'h0000_0000_00ab_cdef, 4'd3, 1'b1, 1'b0, 31'd11}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'h8000_0000_0000_0001, 4'd8, 1'b0, 1'b1, 31'd0}, CHK_ERR, '{64'h0, 1'b1}},
        '{'{64'h1234_5678_9abc_def0, 4'd0, 1'b1, 1'b0, 31'd8}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'h7fff_ffff_ffff_ffff, 4'd8, 1'b0, 1'b1, 31'd0}, CHK_ERR, '{64'h0, 1'b1}},
        '{'{ONES, 4'd8, 1'b1, 1'b0, 31'h7FFF_FFFF}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'h0, 4'd8, 1'b0, 1'b1, 31'd0}, CHK_ERR, '{64'h0, 1'b1}},
        '{'{64'haaaa_aaaa_aaaa_aaaa, 4'd8, 1'b0, 1'b0, 31'd0}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'h5555_5555_5555_5555, 4'd8, 1'b0, 1'b1, 31'd0}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'h0102_0304_0506_0708, 4'd12, 1'b1, 1'b0, 31'd8}, CHK_MODEL, '{64'h0, 1'b0}},
        '{'{64'h1122_3344_5566_7788, 4'd8, 1'b0, 1'b1, 31'd0}, CHK_ERR, '{64'h0, 1'b1}},
        '{'{64'h0000_0000_7766_5544, 4'd4, 1'b1, 1'b1, 31'd0}, CHK_ERR, '{64'h0, 1'b1}}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [DATA_W-1:0]    i_cfg_data = '0;

    // Predictor state.
    logic [63:0] seed_q = '0;
    logic [63:0] run_hash = '0;
    logic [31:0] seen_bytes = '0;
    logic [30:0] want_len = '0;
    logic        fault = 1'b0;

    t_digest pending_digests[$];
    t_digest got_digest;

    int cycle_count = 0;
    int items_sent = 0;
    int messages_sent = 0;
    int hashes_checked = 0;
    int errors_flagged = 0;
    int seeds_written = 0;
    int mismatches = 0;
    int tx_gap_pct = 0;
    int rx_idle_pct = 0;
    int rx_stall = 0;
    bit rx_hold_req = 1'b0;

    murmur_hash_64a_stream u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t ns: timeout with %0d hashes outstanding", $time,
                     pending_digests.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [63:0] hash_finish(input logic [63:0] h);
        logic [63:0] x;
        x = h ^ (h >> MIX_SHIFT);
        x = x * MIX_MUL;
        return x ^ (x >> MIX_SHIFT);
    endfunction

    task automatic hash_absorb(input t_hash_item it, output bit emits, output t_digest d);
        logic [63:0] k;
        logic [63:0] mask;
        if (it.first) begin
            want_len   = it.len;
            run_hash   = seed_q ^ ({33'd0, it.len} * MIX_MUL);
            seen_bytes = '0;
            fault      = 1'b0;
        end
        if (it.cnt == CNT_FULL) begin
            k = it.word * MIX_MUL;
            k = k ^ (k >> MIX_SHIFT);
            k = k * MIX_MUL;
            run_hash   = (run_hash ^ k) * MIX_MUL;
            seen_bytes = seen_bytes + 32'd8;
        end else if (it.cnt > CNT_FULL) begin
            fault = 1'b1;
        end else begin
            if (!it.last) begin
                fault = 1'b1;
            end
            if (it.cnt != 4'd0) begin
                mask       = (64'd1 << (8 * it.cnt)) - 64'd1;
                run_hash   = (run_hash ^ (it.word & mask)) * MIX_MUL;
                seen_bytes = seen_bytes + {28'd0, it.cnt};
            end
        end
        emits  = it.last;
        d.hash = hash_finish(run_hash);
        d.err  = fault || (seen_bytes != {1'b0, want_len});
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input t_hash_item it, input t_chk chk, input t_digest want);
        bit      emits;
        t_digest d;
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        s_axis_tdata  <= {5'd0, it.len, it.cnt, it.word};
        s_axis_tuser  <= it.first;
        s_axis_tlast  <= it.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        hash_absorb(it, emits, d);
        if (emits) begin
            if (chk == CHK_TYPED) begin
                d = want;
            end else if (chk == CHK_ERR) begin
                d.err = want.err;
            end
            pending_digests.push_back(d);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        while (pending_digests.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        seed_q = value;
        seeds_written++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly well-formed messages with random content; about one in five is damaged.
    task automatic send_message(input bit calm);
        t_hash_item msg[$];
        t_hash_item it;
        t_digest    none;
        int         n;
        int         r;
        int         idx;
        none = '{64'h0, 1'b0};
        r = $urandom_range(0, 99);
        if (r < 70) begin
            n = $urandom_range(0, 40);
        end else if (r < 95) begin
            n = $urandom_range(41, 120);
        end else begin
            n = $urandom_range(121, 400);
        end
        for (int i = 0; i < n / 8; i++) begin
            msg.push_back('{{$urandom, $urandom}, CNT_FULL, 1'b0, 1'b0, 31'd0});
        end
        if (n % 8 != 0) begin
            msg.push_back('{{$urandom, $urandom}, 4'(n % 8), 1'b0, 1'b0, 31'd0});
        end else if (n == 0 || $urandom_range(0, 1) == 0) begin
            msg.push_back('{{$urandom, $urandom}, 4'd0, 1'b0, 1'b0, 31'd0});
        end
        msg[0].first = 1'b1;
        msg[0].len   = 31'(n);
        msg[msg.size() - 1].last = 1'b1;
        if ($urandom_range(0, 4) == 0) begin
            idx = $urandom_range(0, msg.size() - 1);
            case ($urandom_range(0, 4))
                0: msg[0].len = 31'($urandom);
                1: msg[0].first = 1'b0;
                2: msg[idx].cnt = 4'($urandom_range(0, 15));
                3: begin
                    it = '{{$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0, 1'b0,
                           31'($urandom)};
                    msg.insert(idx, it);
                end
                default: if (idx < msg.size() - 1) msg[idx].last = 1'b1;
            endcase
        end
        if (!calm) begin
            tx_gap_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
            rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
        end
        foreach (msg[i]) begin
            send_item(msg[i], CHK_MODEL, none);
        end
        messages_sent++;
    endtask

    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_stall = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            rx_stall = $urandom_range(1, 18) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (m_axis_tuser) begin
                errors_flagged++;
            end
            if (pending_digests.size() == 0) begin
                mismatches++;
                $display("%0t ns: hash transfer with none expected, got %h err %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                got_digest = pending_digests.pop_front();
                hashes_checked++;
                if (m_axis_tdata !== got_digest.hash || m_axis_tuser !== got_digest.err) begin
                    mismatches++;
                    $display("%0t ns: hash expected %h err %b, got %h err %b", $time,
                             got_digest.hash, got_digest.err, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    initial begin
        logic [63:0] phase_seeds [5];
        int          target;
        int          phase_msgs;
        phase_seeds = '{ONES, {$urandom, $urandom}, 64'h1, 64'h8000_0000_0000_0000,
                        {$urandom, $urandom}};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_seed(64'h0);
        tx_gap_pct  = 10;
        rx_idle_pct = 15;
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].want);
        end
        drain_stream();

        for (int p = 0; p < 5; p++) begin
            write_seed(phase_seeds[p]);
            if (p == 4) begin
                tx_gap_pct  = 0;
                rx_idle_pct = 0;
            end
            target = $size(dir_rows) + (RUN_ITEMS * (p + 1)) / 5;
            phase_msgs = 0;
            while (items_sent < target) begin
                send_message(p == 4);
                phase_msgs++;
                if (p == 1 && phase_msgs == 3) begin
                    rx_hold_req = 1'b1;
                end
            end
            drain_stream();
        end

        $display("Sent %0d items in %0d messages under %0d seed writes.", items_sent,
                 messages_sent, seeds_written);
        $display("Checked %0d hashes, %0d of them flagged with a length error.",
                 hashes_checked, errors_flagged);
        if (mismatches == 0 && pending_digests.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/mmh64_pkg.sv
sv/mmh64_datapath.sv
sv/mmh64_controller.sv
sv/murmur_hash_64a_stream.sv
sv/mmh64_checker.sv
tb/tb.sv
